>>> hdl/text_terminal_cursor_scroll_assert.svh
// Assertion macros for the text terminal block.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH

`define TTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TTS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hdl/tts_pkg.sv
package tts_pkg;

  localparam int unsigned ScreenColumns = 80;
  localparam int unsigned ScreenRows    = 25;

  localparam logic [7:0] NewlineChar    = 8'h0A;
  localparam logic [7:0] NullChar       = 8'h00;
  localparam logic [7:0] SpaceChar      = 8'h20;
  localparam logic [7:0] BlankColor     = 8'h07;
  localparam logic [7:0] ResetTextColor = 8'h07;

  typedef enum logic [1:0] {
    OpPut  = 2'd0,
    OpMove = 2'd1,
    OpFill = 2'd2,
    OpRead = 2'd3
  } op_e;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] code;
  } cell_t;

  localparam cell_t BlankCell = '{color: BlankColor, code: SpaceChar};

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
    logic [6:0] end_col;
    logic [4:0] end_row;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
  } out_item_t;

endpackage

>>> hdl/text_terminal_cursor_scroll.sv
// Character-cell text terminal: a SCREEN_COLUMNS x SCREEN_ROWS store of
// character/attribute cells plus a cursor, held in one single-port-write,
// registered-read memory.
// in channel: one transaction per operation (put char, move cursor, fill
// region, read cell). out channel: one result transaction per operation,
// carrying the cursor after the operation, a scroll flag and the read cell.
// cfg channel: writes the attribute byte used by put and fill; always ready.
// Each operation passes through an execute state and a done state that posts
// the result; an in-range read adds a state that takes the registered memory
// read data. Fill makes one memory write per cell in the region, one memory
// write per cycle. On a scroll, rows form a ring with a top pointer, so only
// the new bottom row is blanked, one cell per cycle.
// in_ready_o rises in the same cycle that the result is posted, so a new
// operation is accepted only after the last one has posted its result.
// After reset the block sweeps the whole store to blanks (space, 0x07) with
// in_ready_o low.
// The cursor resets to 0,0 and the attribute to 0x07. A result waits in an
// output register; the next operation is accepted and executed meanwhile,
// and only its own completion waits on out_ready_i.
`include "text_terminal_cursor_scroll_assert.svh"

module text_terminal_cursor_scroll import tts_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumns,
  parameter int unsigned SCREEN_ROWS    = ScreenRows
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned Depth = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]       text_color_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  cell_t            mem_wdata;
  cell_t            mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= ResetTextColor;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_color_q <= cfg_data_i;
    end
  end

  tts_ctrl #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_color_i(text_color_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tts_cell_mem #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_cell_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  `TTS_ASSERT_IMPL(a_col_range, out_valid_o, 8'(out_data_o.cursor_col) < 8'(SCREEN_COLUMNS), "cursor column out of range")
  `TTS_ASSERT_IMPL(a_row_range, out_valid_o, 7'(out_data_o.cursor_row) < 7'(SCREEN_ROWS), "cursor row out of range")
  `TTS_ASSERT_IMPL(a_scroll_col, out_valid_o && out_data_o.scrolled, out_data_o.cursor_col == 7'd0, "scroll left cursor off column 0")
  `TTS_ASSERT(a_scroll_no_read, !(out_valid_o && out_data_o.scrolled) || (out_data_o.cell_char == 8'd0 && out_data_o.cell_color == 8'd0), "scrolling result carries cell data")

endmodule

>>> hdl/tts_addr_map.sv
module tts_addr_map import tts_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumns,
  parameter int unsigned SCREEN_ROWS    = ScreenRows,
  localparam int unsigned Depth   = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned RowIdxW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1
) (
  input  logic [RowIdxW-1:0] top_i,
  input  logic [6:0]         col_i,
  input  logic [6:0]         row_i,
  output logic [AddrW-1:0]   addr_o
);

  localparam logic [6:0] RowsW = 7'(SCREEN_ROWS);

  logic [6:0] row_sum;
  logic [6:0] phys_row;

  // Rows live in a ring: logical row 0 sits at physical row top_i.
  always_comb begin
    row_sum  = row_i + 7'(top_i);
    phys_row = (row_sum >= RowsW) ? row_sum - RowsW : row_sum;
    addr_o   = AddrW'(phys_row) * AddrW'(SCREEN_COLUMNS) + AddrW'(col_i);
  end

endmodule

>>> hdl/tts_cell_mem.sv
module tts_cell_mem import tts_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumns,
  parameter int unsigned SCREEN_ROWS    = ScreenRows,
  localparam int unsigned Depth = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  cell_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output cell_t            rdata_o
);

  cell_t cells_q [Depth];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cells_q[waddr_i] <= wdata_i;
    end
    rdata_q <= cells_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tts_ctrl.sv
module tts_ctrl import tts_pkg::*; #(
  parameter int unsigned SCREEN_COLUMNS = ScreenColumns,
  parameter int unsigned SCREEN_ROWS    = ScreenRows,
  localparam int unsigned Depth   = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned RowIdxW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       text_color_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output cell_t            mem_wdata_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  cell_t            mem_rdata_i
);

  localparam logic [7:0]         ColsW    = 8'(SCREEN_COLUMNS);
  localparam logic [6:0]         RowsW    = 7'(SCREEN_ROWS);
  localparam logic [6:0]         LastCol  = 7'(SCREEN_COLUMNS - 1);
  localparam logic [6:0]         LastRow  = 7'(SCREEN_ROWS - 1);
  localparam logic [RowIdxW-1:0] LastTop  = RowIdxW'(SCREEN_ROWS - 1);
  localparam logic [AddrW-1:0]   LastAddr = AddrW'(Depth - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StExec,
    StFill,
    StScroll,
    StReadTake,
    StDone
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [RowIdxW-1:0] top_q, top_d;
  logic [6:0]         cur_col_q, cur_col_d;
  logic [4:0]         cur_row_q, cur_row_d;
  logic               out_valid_q, out_valid_d;

  in_item_t           item_q, item_d;
  logic [6:0]         ec_q, ec_d;
  logic [4:0]         er_q, er_d;
  logic [6:0]         x_q, x_d;
  logic [6:0]         y_q, y_d;
  logic               scrolled_q, scrolled_d;
  cell_t              rd_cell_q, rd_cell_d;
  out_item_t          out_q, out_d;

  logic [AddrW-1:0]   map_addr;
  logic               new_line;

  tts_addr_map #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_addr_map (
    .top_i (top_q),
    .col_i (x_q),
    .row_i (y_q),
    .addr_o(map_addr)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    top_d       = top_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    ec_d        = ec_q;
    er_d        = er_q;
    x_d         = x_q;
    y_d         = y_q;
    scrolled_d  = scrolled_q;
    rd_cell_d   = rd_cell_q;
    out_d       = out_q;
    new_line    = 1'b0;

    in_ready_o  = (state_q == StIdle);
    mem_we_o    = 1'b0;
    mem_waddr_o = map_addr;
    mem_raddr_o = map_addr;
    mem_wdata_o = '{color: text_color_i, code: item_q.char_code};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = BlankCell;
        clr_d       = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (in_valid_i) begin
          item_d     = in_data_i;
          ec_d       = ({1'b0, in_data_i.end_col} > ColsW) ? ColsW[6:0] : in_data_i.end_col;
          er_d       = ({2'b0, in_data_i.end_row} > RowsW) ? RowsW[4:0] : in_data_i.end_row;
          scrolled_d = 1'b0;
          rd_cell_d  = '0;
          if (in_data_i.op == OpPut) begin
            x_d = cur_col_q;
            y_d = 7'(cur_row_q);
          end else begin
            x_d = in_data_i.col;
            y_d = 7'(in_data_i.row);
          end
          state_d = StExec;
        end
      end

      StExec: begin
        state_d = StDone;
        case (item_q.op)
          OpPut: begin
            if (item_q.char_code == NewlineChar) begin
              new_line = 1'b1;
            end else if (item_q.char_code != NullChar) begin
              mem_we_o = 1'b1;
              if ({1'b0, cur_col_q} + 8'd1 >= ColsW) begin
                new_line = 1'b1;
              end else begin
                cur_col_d = cur_col_q + 7'd1;
              end
            end
            if (new_line) begin
              cur_col_d = '0;
              if ({2'b0, cur_row_q} + 7'd1 < RowsW) begin
                cur_row_d = cur_row_q + 5'd1;
              end else begin
                // old top row turns into the new bottom row and gets blanked
                top_d      = (top_q == LastTop) ? '0 : top_q + RowIdxW'(1);
                x_d        = '0;
                y_d        = LastRow;
                scrolled_d = 1'b1;
                state_d    = StScroll;
              end
            end
          end
          OpMove: begin
            cur_col_d = ({1'b0, item_q.col} < ColsW) ? item_q.col : LastCol;
            cur_row_d = ({2'b0, item_q.row} < RowsW) ? item_q.row : LastRow[4:0];
          end
          OpFill: begin
            if (x_q < ec_q && y_q < {2'b0, er_q}) begin
              state_d = StFill;
            end
          end
          OpRead: begin
            if ({1'b0, x_q} < ColsW && y_q < RowsW) begin
              state_d = StReadTake;
            end
          end
          default: begin
            state_d = StDone;
          end
        endcase
      end

      StFill: begin
        mem_we_o = 1'b1;
        if (x_q + 7'd1 == ec_q) begin
          x_d = item_q.col;
          if (y_q + 7'd1 == {2'b0, er_q}) begin
            state_d = StDone;
          end else begin
            y_d = y_q + 7'd1;
          end
        end else begin
          x_d = x_q + 7'd1;
        end
      end

      StScroll: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = BlankCell;
        if (x_q == LastCol) begin
          state_d = StDone;
        end else begin
          x_d = x_q + 7'd1;
        end
      end

      StReadTake: begin
        rd_cell_d = mem_rdata_i;
        state_d   = StDone;
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{cursor_col: cur_col_q,
                          cursor_row: cur_row_q,
                          scrolled:   scrolled_q,
                          cell_char:  rd_cell_q.code,
                          cell_color: rd_cell_q.color};
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      top_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      top_q       <= top_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ec_q       <= ec_d;
    er_q       <= er_d;
    x_q        <= x_d;
    y_q        <= y_d;
    scrolled_q <= scrolled_d;
    rd_cell_q  <= rd_cell_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
